FILE: rtl/core/cidw_pkg.sv
// shared types and constants for the can id whitelist rate divider
`default_nettype none

package cidw_pkg;

   localparam int ID_W        = 29;
   localparam int STD_W       = 11;
   localparam int SLOT_W      = 6;
   localparam int DIV_W       = 8;
   localparam int CNT_W       = 8;
   localparam int QUEUE_DEPTH = 2;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_MSG  = 1'b1;

   typedef struct packed {
      logic              op;
      logic [SLOT_W-1:0] slot;
      logic [ID_W-1:0]   slot_id;
      logic [DIV_W-1:0]  slot_divisor;
      logic              is_extended;
      logic [STD_W-1:0]  std_id;
      logic [ID_W-1:0]   ext_id;
   } req_type;

   typedef struct packed {
      logic            forward;
      logic            matched;
      logic [ID_W-1:0] resolved_id;
   } rsp_type;

   typedef enum logic [1:0] {
      CMD_LOAD   = 2'd0,
      CMD_SKIP   = 2'd1,
      CMD_PASS   = 2'd2,
      CMD_LOOKUP = 2'd3
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic [SLOT_W-1:0] slot;
      logic [ID_W-1:0]   slot_id;
      logic [DIV_W-1:0]  divisor;
      logic [ID_W-1:0]   resolved_id;
   } cmd_type;

endpackage

`default_nettype wire

FILE: rtl/core/cidw_front.sv
// request intake: pass-all register and classification of each request
`default_nettype none

module cidw_front
   import cidw_pkg::*;
#(
   parameter int ENTRIES = 64
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   input  wire logic    csr_wr_en,
   input  wire logic    csr_wr_data,
   input  wire logic    q_full,
   output logic         push,
   output cmd_type      push_data
);

   logic pass_all_ff;
   logic pass_all_in;
   logic slot_in_range;

   assign pass_all_in = csr_wr_en ? csr_wr_data : pass_all_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pass_all_ff <= 1'b0;
      end else begin
         pass_all_ff <= pass_all_in;
      end
   end

   assign req_ready     = !q_full;
   assign push          = req_valid && req_ready;
   assign slot_in_range = ({{(32-SLOT_W){1'b0}}, req_data.slot} < 32'(ENTRIES));

   always_comb begin
      push_data.slot        = req_data.slot;
      push_data.slot_id     = req_data.slot_id;
      push_data.divisor     = req_data.slot_divisor;
      push_data.resolved_id = req_data.is_extended ? req_data.ext_id
                                                   : ID_W'(req_data.std_id);
      if (req_data.op == OP_LOAD) begin
         // loads past the end of the table are dropped
         push_data.kind = slot_in_range ? CMD_LOAD : CMD_SKIP;
      end else begin
         push_data.kind = pass_all_ff ? CMD_PASS : CMD_LOOKUP;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/cidw_queue.sv
// short command queue between intake and table engine
`default_nettype none

module cidw_queue
   import cidw_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_data,
   output logic         full,
   input  wire logic    pop,
   output logic         pop_valid,
   output cmd_type      pop_data
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

   cmd_type           slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_QW-1:0] count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign full      = (count_ff == CNT_QW'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/cidw_back.sv
// table engine: slot loads, whitelist walk, decimation counters, response register
`default_nettype none

module cidw_back
   import cidw_pkg::*;
#(
   parameter int ENTRIES = 64
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    cmd_valid,
   output logic         cmd_ready,
   input  wire cmd_type cmd_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   state_type         state_ff, state_in;

   logic [ID_W-1:0]   id_mem  [ENTRIES];
   logic [DIV_W-1:0]  div_mem [ENTRIES];
   logic [CNT_W-1:0]  cnt_mem [ENTRIES];
   logic [ID_W-1:0]   id_rd_ff;
   logic [DIV_W-1:0]  div_rd_ff;
   logic [CNT_W-1:0]  cnt_rd_ff;

   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [IDX_W-1:0]  rd_addr_ff, rd_addr_in;
   logic [IDX_W-1:0]  cmp_idx_ff, cmp_idx_in;
   logic              cmp_vld_ff, cmp_vld_in;
   logic [ID_W-1:0]   rid_ff, rid_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              out_free;
   logic              take;
   logic              hit;
   logic [DIV_W:0]    cnt_next;
   logic [DIV_W:0]    div_mod;
   logic [CNT_W-1:0]  cnt_wrap;
   logic              tbl_we;
   logic [IDX_W-1:0]  tbl_addr;
   logic              cnt_we;
   logic [IDX_W-1:0]  cnt_addr;
   logic [CNT_W-1:0]  cnt_wdata;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign cmd_ready = (state_ff == ST_IDLE) && out_free;
   assign take      = cmd_valid && cmd_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // compare stage sees the entry fetched on the previous cycle
   assign hit = cmp_vld_ff && valid_ff[cmp_idx_ff] && (id_rd_ff == rid_ff);

   // a stored divisor of zero counts as 256
   assign cnt_next = {1'b0, cnt_rd_ff} + 1'b1;
   assign div_mod  = (div_rd_ff == '0) ? ((DIV_W+1)'(1) << DIV_W) : {1'b0, div_rd_ff};
   assign cnt_wrap = (cnt_next >= div_mod) ? '0 : cnt_next[CNT_W-1:0];

   always_comb begin
      state_in     = state_ff;
      rd_addr_in   = rd_addr_ff;
      cmp_idx_in   = rd_addr_ff;
      cmp_vld_in   = 1'b0;
      rid_in       = rid_ff;
      valid_in     = valid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      tbl_we       = 1'b0;
      tbl_addr     = IDX_W'(cmd_data.slot);
      cnt_we       = 1'b0;
      cnt_addr     = IDX_W'(cmd_data.slot);
      cnt_wdata    = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               rsp_data_in = '0;
               unique case (cmd_data.kind)
                  CMD_LOAD: begin
                     tbl_we             = 1'b1;
                     cnt_we             = 1'b1;
                     valid_in[tbl_addr] = 1'b1;
                     rsp_valid_in       = 1'b1;
                  end
                  CMD_SKIP: begin
                     rsp_valid_in = 1'b1;
                  end
                  CMD_PASS: begin
                     rsp_data_in.forward     = 1'b1;
                     rsp_data_in.resolved_id = cmd_data.resolved_id;
                     rsp_valid_in            = 1'b1;
                  end
                  CMD_LOOKUP: begin
                     rid_in     = cmd_data.resolved_id;
                     rd_addr_in = '0;
                     state_in   = ST_SCAN;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            cmp_vld_in = 1'b1;
            if (rd_addr_ff != LAST_IDX) begin
               rd_addr_in = rd_addr_ff + 1'b1;
            end
            if (hit) begin
               cnt_we                  = 1'b1;
               cnt_addr                = cmp_idx_ff;
               cnt_wdata               = cnt_wrap;
               rsp_valid_in            = 1'b1;
               rsp_data_in.forward     = (cnt_wrap == '0);
               rsp_data_in.matched     = 1'b1;
               rsp_data_in.resolved_id = rid_ff;
               cmp_vld_in              = 1'b0;
               state_in                = ST_IDLE;
            end else if (cmp_vld_ff && (cmp_idx_ff == LAST_IDX)) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.forward     = 1'b0;
               rsp_data_in.matched     = 1'b0;
               rsp_data_in.resolved_id = rid_ff;
               cmp_vld_in              = 1'b0;
               state_in                = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rd_addr_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_addr_ff   <= rd_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff  <= cmp_idx_in;
      rid_ff      <= rid_in;
      rsp_data_ff <= rsp_data_in;
   end

   // whitelist table, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (tbl_we) begin
         id_mem[tbl_addr]  <= cmd_data.slot_id;
         div_mem[tbl_addr] <= cmd_data.divisor;
      end
      if (cnt_we) begin
         cnt_mem[cnt_addr] <= cnt_wdata;
      end
      id_rd_ff  <= id_mem[rd_addr_ff];
      div_rd_ff <= div_mem[rd_addr_ff];
      cnt_rd_ff <= cnt_mem[rd_addr_ff];
   end

endmodule

`default_nettype wire

FILE: rtl/core/can_id_whitelist_rate_divider.sv
// top level: can acceptance filter with per-identifier forwarding divider
`default_nettype none

// Each request is either a table load or a received CAN frame, and each gives
// exactly one response. A load, a load to a slot beyond the table, or a frame
// while pass-all is set is answered straight from the idle state. A frame
// lookup walks the whitelist one entry per cycle, from slot 0 upward, through
// a table memory with a registered read once the request leaves the two-entry
// command queue; the first match answers, else the walk ends at the last slot.
// The table memory comes out of reset unwritten; only its valid bits clear.
module can_id_whitelist_rate_divider
   import cidw_pkg::*;
#(
   parameter int ENTRIES = 64
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data,
   input  wire logic    csr_wr_en,
   input  wire logic    csr_wr_data
);

   logic    q_full;
   logic    push;
   cmd_type push_data;
   logic    pop;
   logic    pop_valid;
   cmd_type pop_data;

   cidw_front #(
      .ENTRIES (ENTRIES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_full      (q_full),
      .push        (push),
      .push_data   (push_data)
   );

   cidw_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_data  (pop_data)
   );

   cidw_back #(
      .ENTRIES (ENTRIES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (pop_valid),
      .cmd_ready (pop),
      .cmd_data  (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// testbench for the can id whitelist rate divider: directed table, random traffic, checking
`default_nettype none

module tb_top;
   import cidw_pkg::*;

   localparam int TBL_DEPTH  = 64;
   localparam int MAX_GAP    = 13;
   localparam int CYCLE_CAP  = 1_000_000;
   localparam int FOCUS_LEN  = 450;
   localparam int SHOW_LIMIT = 10;

   typedef struct {
      logic    pass_all;
      req_type req;
      logic    typed;
      rsp_type rsp;
   } dir_row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   logic    csr_wr_en;
   logic    csr_wr_data;

   // shadow copy of the whitelist and the pass-all register
   logic             tbl_valid [TBL_DEPTH];
   logic [ID_W-1:0]  tbl_id    [TBL_DEPTH];
   logic [DIV_W-1:0] tbl_div   [TBL_DEPTH];
   logic [CNT_W-1:0] tbl_cnt   [TBL_DEPTH];
   logic             pass_mode;

   rsp_type     expected_rsp [$];
   dir_row_type dir_rows [$];

   int  mismatches  = 0;
   int  sent_count  = 0;
   int  rsp_count   = 0;
   int  fwd_count   = 0;
   int  hit_count   = 0;
   int  cycle_count = 0;
   bit  req_burst   = 0;
   bit  rsp_burst   = 0;
   int  focus_slot  = 0;
   int  focus_age   = FOCUS_LEN;
   int  focus_round = 0;

   can_id_whitelist_rate_divider #(.ENTRIES(TBL_DEPTH)) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_CAP) begin
         $display("[can_id_whitelist_rate_divider] ERROR");
         $finish;
      end
   end

   // occasionally flip between bursts with no idling and random waits
   function automatic int draw_gap(inout bit burst);
      if ($urandom_range(0, 63) == 0) burst = ~burst;
      return burst ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   function automatic rsp_type predict_filter(input req_type r);
      rsp_type          o;
      logic [ID_W-1:0]  rid;
      logic [8:0]       nxt;
      logic [8:0]       lim;
      bit               found;
      int               i;
      o = '0;
      found = 0;
      if (r.op == OP_LOAD) begin
         tbl_valid[r.slot] = 1'b1;
         tbl_id[r.slot]    = r.slot_id;
         tbl_div[r.slot]   = r.slot_divisor;
         tbl_cnt[r.slot]   = '0;
         return o;
      end
      rid = r.is_extended ? r.ext_id : {{(ID_W-STD_W){1'b0}}, r.std_id};
      o.resolved_id = rid;
      if (pass_mode) begin
         o.forward = 1'b1;
         return o;
      end
      for (i = 0; i < TBL_DEPTH; i++) begin
         if (!found && tbl_valid[i] && tbl_id[i] == rid) begin
            found = 1;
            // divisor zero acts as 256, so the 8-bit counter just wraps
            lim = (tbl_div[i] == 0) ? 9'd256 : {1'b0, tbl_div[i]};
            nxt = {1'b0, tbl_cnt[i]} + 9'd1;
            if (nxt >= lim) nxt = '0;
            tbl_cnt[i] = nxt[CNT_W-1:0];
            o.matched  = 1'b1;
            o.forward  = (nxt == 0);
         end
      end
      return o;
   endfunction

   function automatic req_type make_load(input int slot, input int id, input int div);
      req_type r;
      r = '0;
      r.op           = OP_LOAD;
      r.slot         = SLOT_W'(slot);
      r.slot_id      = ID_W'(id);
      r.slot_divisor = DIV_W'(div);
      r.is_extended  = 1'($urandom_range(0, 1));
      r.std_id       = STD_W'($urandom);
      r.ext_id       = ID_W'($urandom);
      return r;
   endfunction

   // unused id field carries junk so it is seen to be ignored
   function automatic req_type make_msg(input bit ext, input int id);
      req_type r;
      r = '0;
      r.op           = OP_MSG;
      r.slot         = SLOT_W'($urandom);
      r.slot_id      = ID_W'($urandom);
      r.slot_divisor = DIV_W'($urandom);
      r.is_extended  = ext;
      r.std_id       = ext ? STD_W'($urandom) : STD_W'(id);
      r.ext_id       = ext ? ID_W'(id) : ID_W'($urandom);
      return r;
   endfunction

   function automatic req_type msg_for_id(input logic [ID_W-1:0] id);
      bit ext;
      ext = (id >= 2048) || ($urandom_range(0, 1) == 1);
      return make_msg(ext, int'(id));
   endfunction

   function automatic int random_divisor();
      int roll;
      roll = $urandom_range(0, 19);
      if (roll == 0) return 0;
      if (roll == 1) return 255;
      if (roll < 6) return $urandom_range(1, 255);
      return $urandom_range(1, 8);
   endfunction

   // mostly traffic aimed at loaded ids, one slot hammered long enough to wrap
   function automatic req_type random_request();
      req_type r;
      int      roll;
      int      s;
      int      id;
      focus_age++;
      if (focus_age >= FOCUS_LEN) begin
         focus_age  = 0;
         focus_slot = $urandom_range(0, TBL_DEPTH - 1);
         id = $urandom_range(0, 1) ? $urandom_range(0, 2047) : $urandom;
         case (focus_round % 3)
            0: r = make_load(focus_slot, id, 0);
            1: r = make_load(focus_slot, id, 255);
            default: r = make_load(focus_slot, id, $urandom_range(1, 8));
         endcase
         focus_round++;
         return r;
      end
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
         s = $urandom_range(0, TBL_DEPTH - 1);
         if (s == focus_slot) s = (s + 1) % TBL_DEPTH;
         case ($urandom_range(0, 2))
            0: id = $urandom_range(0, 2047);
            1: id = int'(tbl_id[$urandom_range(0, TBL_DEPTH - 1)]);
            default: id = $urandom;
         endcase
         return make_load(s, id, random_divisor());
      end
      if (roll < 72) return msg_for_id(tbl_id[focus_slot]);
      if (roll < 88) return msg_for_id(tbl_id[$urandom_range(0, TBL_DEPTH - 1)]);
      if ($urandom_range(0, 1)) return make_msg(1'b0, $urandom_range(0, 2047));
      return make_msg(1'b1, $urandom);
   endfunction

   // entered and left at a falling edge; valid stays up for a back-to-back request
   task automatic send_request(input req_type r, input logic typed, input rsp_type want);
      int      gap;
      rsp_type pred;
      gap = draw_gap(req_burst);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      pred = predict_filter(r);
      expected_rsp.push_back(typed ? want : pred);
      sent_count++;
      @(negedge clock);
   endtask

   task automatic write_pass_all(input logic v);
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      pass_mode = v;
   endtask

   task automatic note_mismatch(input string what, input longint unsigned want,
                                input longint unsigned got);
      mismatches++;
      if (mismatches <= SHOW_LIMIT)
         $display("mismatch %0d: %s expected 0x%0h got 0x%0h", mismatches, what, want, got);
   endtask

   task automatic check_response(input rsp_type got);
      rsp_type want;
      rsp_count++;
      fwd_count += int'(got.forward);
      hit_count += int'(got.matched);
      if (expected_rsp.size() == 0) begin
         note_mismatch("unexpected response, resolved_id", 0, got.resolved_id);
         return;
      end
      want = expected_rsp.pop_front();
      if (got.forward !== want.forward)
         note_mismatch("forward", want.forward, got.forward);
      if (got.matched !== want.matched)
         note_mismatch("matched", want.matched, got.matched);
      if (got.resolved_id !== want.resolved_id)
         note_mismatch("resolved_id", want.resolved_id, got.resolved_id);
   endtask

   // response side: random stalls before each response
   initial begin
      int stall;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         stall = draw_gap(rsp_burst);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         check_response(rsp_data);
         @(negedge clock);
      end
   end

   initial begin
      rsp_type zero_rsp;
      rsp_type fwd_rsp;
      int      i;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      rsp_ready   = 1'b0;
      csr_wr_en   = 1'b0;
      csr_wr_data = 1'b0;
      pass_mode   = 1'b0;
      zero_rsp    = '0;
      for (i = 0; i < TBL_DEPTH; i++) begin
         tbl_valid[i] = 1'b0;
         tbl_cnt[i]   = '0;
      end
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // fill every slot so no lookup ever touches an unwritten entry
      for (i = 0; i < TBL_DEPTH; i++)
         send_request(make_load(i, $urandom_range(32'h1000_0000, 32'h1FFF_FFFE),
                                $urandom_range(0, 255)), 1'b0, zero_rsp);

      dir_rows.push_back('{1'b0, make_load(0, 0, 1), 1'b1, zero_rsp});
      dir_rows.push_back('{1'b0, make_load(63, 32'h1FFF_FFFF, 255), 1'b1, zero_rsp});
      dir_rows.push_back('{1'b0, make_load(5, 32'h7FF, 0), 1'b1, zero_rsp});
      // same id again further up: the lower slot has to win
      dir_rows.push_back('{1'b0, make_load(6, 32'h7FF, 2), 1'b1, zero_rsp});
      dir_rows.push_back('{1'b0, make_msg(1'b0, 0), 1'b0, zero_rsp});
      dir_rows.push_back('{1'b0, make_msg(1'b1, 0), 1'b0, zero_rsp});
      dir_rows.push_back('{1'b0, make_msg(1'b0, 32'h7FF), 1'b0, zero_rsp});
      dir_rows.push_back('{1'b0, make_msg(1'b1, 32'h7FF), 1'b0, zero_rsp});
      dir_rows.push_back('{1'b0, make_msg(1'b1, 32'h1FFF_FFFF), 1'b0, zero_rsp});
      dir_rows.push_back('{1'b0, make_msg(1'b0, 32'h123), 1'b1, '{1'b0, 1'b0, 29'h123}});
      dir_rows.push_back('{1'b0, make_msg(1'b1, 32'h0FFF_FFFF), 1'b1,
                           '{1'b0, 1'b0, 29'h0FFF_FFFF}});
      // reload clears the counter
      dir_rows.push_back('{1'b0, make_load(63, 32'h1FFF_FFFF, 1), 1'b1, zero_rsp});
      dir_rows.push_back('{1'b0, make_msg(1'b1, 32'h1FFF_FFFF), 1'b0, zero_rsp});
      dir_rows.push_back('{1'b0, make_load(7, 32'h155, 3), 1'b1, zero_rsp});
      for (i = 0; i < 3; i++)
         dir_rows.push_back('{1'b0, make_msg(1'b0, 32'h155), 1'b0, zero_rsp});
      fwd_rsp = '{1'b1, 1'b0, 29'h1FFF_FFFF};
      dir_rows.push_back('{1'b1, make_msg(1'b1, 32'h1FFF_FFFF), 1'b1, fwd_rsp});
      fwd_rsp.resolved_id = 29'h7FF;
      dir_rows.push_back('{1'b1, make_msg(1'b0, 32'h7FF), 1'b1, fwd_rsp});
      fwd_rsp.resolved_id = 29'h2AA;
      dir_rows.push_back('{1'b1, make_msg(1'b0, 32'h2AA), 1'b1, fwd_rsp});
      dir_rows.push_back('{1'b1, make_load(8, 32'h2AA, 1), 1'b1, zero_rsp});
      dir_rows.push_back('{1'b0, make_msg(1'b0, 32'h2AA), 1'b0, zero_rsp});
      dir_rows.push_back('{1'b0, make_msg(1'b0, 32'h155), 1'b0, zero_rsp});
      dir_rows.push_back('{1'b0, make_msg(1'b0, 32'h7FF), 1'b0, zero_rsp});

      foreach (dir_rows[i]) begin
         if (dir_rows[i].pass_all !== pass_mode) write_pass_all(dir_rows[i].pass_all);
         send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);
      end

      if (pass_mode) write_pass_all(1'b0);
      repeat (950) send_request(random_request(), 1'b0, zero_rsp);
      write_pass_all(1'b1);
      repeat (150) send_request(random_request(), 1'b0, zero_rsp);
      write_pass_all(1'b0);
      repeat (250) send_request(random_request(), 1'b0, zero_rsp);

      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (TBL_DEPTH + 16) @(posedge clock);
      if (expected_rsp.size() != 0) note_mismatch("responses missing", 0, expected_rsp.size());

      $display("sent %0d requests (table fill, %0d directed, random in both filter modes)",
               sent_count, dir_rows.size());
      $display("checked %0d responses: %0d forwarded, %0d whitelist hits, %0d mismatches",
               rsp_count, fwd_count, hit_count, mismatches);
      if (mismatches == 0) begin
         $display("[can_id_whitelist_rate_divider] OK");
      end else begin
         $display("[can_id_whitelist_rate_divider] ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire

FILE: files.f
rtl/core/cidw_pkg.sv
rtl/core/cidw_front.sv
rtl/core/cidw_queue.sv
rtl/core/cidw_back.sv
rtl/core/can_id_whitelist_rate_divider.sv
tb/tb_top.sv
